/* hdl/hbcd_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP body chunk decoder package
// Shared types, codes and character constants for the body decoder.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  // Default width of the chunk size and byte counters.
  localparam int LengthBitsDef = 31;

  // Width of the content length register.
  localparam int CfgW = 31;

  // Depth of the result queue; it must hold at least two entries.
  localparam int OutDepth = 4;

  // Configuration register indexes.
  localparam logic CfgChunkedMode   = 1'b0;
  localparam logic CfgContentLength = 1'b1;

  // Characters that the size line parser looks at.
  localparam logic [7:0] CharSp  = 8'h20;
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharVt  = 8'h0B;
  localparam logic [7:0] CharFf  = 8'h0C;
  localparam logic [7:0] CharCr  = 8'h0D;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEnd     = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PhDone  = 3'd0,
    PhLead  = 3'd1,
    PhHex   = 3'd2,
    PhData  = 3'd3,
    PhCr    = 3'd4,
    PhLf    = 3'd5,
    PhFixed = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes one ASCII hex digit; ok is low for any other character.
  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Whitespace skipped before the first character of a size line.
  function automatic logic is_blank(logic [7:0] c);
    return (c == CharSp) || (c == CharTab) || (c == CharCr) ||
           (c == CharVt) || (c == CharFf);
  endfunction

endpackage

/* hdl/http_body_chunk_decoder.sv */
// ----------------------------------------------------------------------------
// HTTP body chunk decoder
// Parses chunked or fixed-length HTTP message bodies and delivers payload bytes.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock cycle and turns it into at most two
// results: a payload byte, an end-of-body marker or a framing error. The parser
// state is updated in the cycle an input transfer is accepted, and the results go
// into a four-entry result queue that drives the output port one transfer per
// cycle. Each byte yields at most one result except the final byte of a
// fixed-length body, which yields the payload byte and the end marker, so the
// sustained rate is one byte per cycle; the input stalls only while the result
// queue has fewer than two free entries, which happens when the output side is
// stalled. Configuration writes go to plain registers and are sampled when a
// transfer with start_body set arrives.
module http_body_chunk_decoder #(
  parameter int LengthBits = hbcd_pkg::LengthBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [hbcd_pkg::CfgW-1:0] cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  hbcd_pkg::in_item_t      in_data_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output hbcd_pkg::out_item_t     out_data_o
);
  import hbcd_pkg::*;

  localparam int PtrW  = $clog2(OutDepth);
  localparam int CntW  = $clog2(OutDepth + 1);
  localparam int WideW = (LengthBits > CfgW) ? LengthBits : CfgW;

  // Configuration registers.
  logic            chunked_mode_q;
  logic [CfgW-1:0] content_length_q;

  // Parser state.
  phase_e                phase_q, phase_d;
  logic [LengthBits-1:0] chunk_size_q, chunk_size_d;
  logic [LengthBits-1:0] bytes_left_q, bytes_left_d;
  logic                  final_chunk_q, final_chunk_d;
  logic                  digits_ended_q, digits_ended_d;

  // Result queue.
  out_item_t      queue_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic            in_accept;
  logic            out_pop;
  logic [1:0]      n_push;
  out_item_t       res0, res1;

  logic [7:0]            c;
  hex_t                  hx;
  logic [LengthBits-1:0] digit_size;
  logic [LengthBits-1:0] bytes_dec;
  logic [WideW-1:0]      cl_wide;
  logic [LengthBits-1:0] cl_sat;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_pop   = out_valid_o && !out_stall_i;

  // Room for two results is needed before a byte is taken.
  assign in_stall_o  = count_q > CntW'(OutDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = queue_q[rd_ptr_q];

  assign c  = in_data_i.data_byte;
  assign hx = hex_digit(c);

  // Append one hex digit to the chunk size, saturating at the all-ones value.
  assign digit_size = (|chunk_size_q[LengthBits-1:LengthBits-4]) ? '1 :
                      {chunk_size_q[LengthBits-5:0], hx.val};

  assign bytes_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : bytes_left_q;

  // Content length clipped to the counter range.
  assign cl_wide = WideW'(content_length_q);
  assign cl_sat  = (cl_wide > WideW'({LengthBits{1'b1}})) ? '1 : cl_wide[LengthBits-1:0];

  // Next state of the parser.
  always_comb begin
    phase_d        = phase_q;
    chunk_size_d   = chunk_size_q;
    bytes_left_d   = bytes_left_q;
    final_chunk_d  = final_chunk_q;
    digits_ended_d = digits_ended_q;
    if (in_data_i.start_body) begin
      chunk_size_d   = '0;
      final_chunk_d  = 1'b0;
      digits_ended_d = 1'b0;
      if (chunked_mode_q) begin
        bytes_left_d = '0;
        phase_d      = PhLead;
      end else begin
        bytes_left_d = cl_sat;
        phase_d      = (cl_sat != '0) ? PhFixed : PhDone;
      end
    end else begin
      case (phase_q)
        PhLead, PhHex: begin
          if (c == CharLf) begin
            // End of the size line: a zero size marks the final chunk.
            bytes_left_d  = chunk_size_q;
            final_chunk_d = chunk_size_q == '0;
            phase_d       = (chunk_size_q != '0) ? PhData : PhCr;
          end else if (phase_q == PhLead && is_blank(c)) begin
            phase_d = PhLead;
          end else if (phase_q == PhLead || !digits_ended_q) begin
            phase_d = PhHex;
            if (hx.ok) begin
              chunk_size_d = digit_size;
            end else begin
              digits_ended_d = 1'b1;
            end
          end
        end
        PhData: begin
          bytes_left_d = bytes_dec;
          if (bytes_dec == '0) begin
            phase_d = PhCr;
          end
        end
        PhCr: begin
          phase_d = (c == CharCr) ? PhLf : PhDone;
        end
        PhLf: begin
          if (c != CharLf || final_chunk_q) begin
            phase_d = PhDone;
          end else begin
            phase_d        = PhLead;
            chunk_size_d   = '0;
            digits_ended_d = 1'b0;
          end
        end
        PhFixed: begin
          bytes_left_d = bytes_dec;
          if (bytes_dec == '0) begin
            phase_d = PhDone;
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end
  end

  // Results caused by the current byte.
  always_comb begin
    n_push = 2'd0;
    res0   = '{out_byte: 8'h00, kind: KindPayload, last: 1'b1};
    res1   = '{out_byte: 8'h00, kind: KindEnd, last: 1'b1};
    if (!in_data_i.start_body) begin
      case (phase_q)
        PhData: begin
          n_push        = 2'd1;
          res0.out_byte = c;
        end
        PhCr: begin
          if (c != CharCr) begin
            n_push    = 2'd1;
            res0.kind = KindError;
          end
        end
        PhLf: begin
          if (c != CharLf) begin
            n_push    = 2'd1;
            res0.kind = KindError;
          end else if (final_chunk_q) begin
            n_push    = 2'd1;
            res0.kind = KindEnd;
          end
        end
        PhFixed: begin
          res0.out_byte = c;
          if (bytes_dec == '0) begin
            n_push    = 2'd2;
            res0.last = 1'b0;
          end else begin
            n_push = 2'd1;
          end
        end
        default: begin
          n_push = 2'd0;
        end
      endcase
    end
    if (!in_accept) begin
      n_push = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_mode_q   <= 1'b1;
      content_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgChunkedMode:   chunked_mode_q   <= cfg_data_i[0];
        CfgContentLength: content_length_q <= cfg_data_i;
        default:          chunked_mode_q   <= chunked_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhDone;
      chunk_size_q   <= '0;
      bytes_left_q   <= '0;
      final_chunk_q  <= 1'b0;
      digits_ended_q <= 1'b0;
    end else if (in_accept) begin
      phase_q        <= phase_d;
      chunk_size_q   <= chunk_size_d;
      bytes_left_q   <= bytes_left_d;
      final_chunk_q  <= final_chunk_d;
      digits_ended_q <= digits_ended_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(n_push) - CntW'(out_pop);
    end
  end

  // The queue never holds more entries than it has.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(OutDepth))
    else $error("result queue overflow");

  // End and error results always close the results of their byte.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KindPayload |-> out_data_o.last)
    else $error("end or error result without last");

  // Only the three defined kinds leave the block.
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind == KindPayload || out_data_o.kind == KindEnd ||
                     out_data_o.kind == KindError))
    else $error("undefined result kind");

  // Payload phases always have bytes left to pass on.
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData || phase_q == PhFixed) |-> bytes_left_q != '0)
    else $error("payload phase with no bytes left");

  // A byte accepted while done produces nothing.
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && phase_q == PhDone && !in_data_i.start_body && !out_pop
      |=> count_q == $past(count_q))
    else $error("result produced while done");

endmodule
